// File: hdl/egss_pkg.sv
`default_nettype none

package egss_pkg;

  // Sizing of the per-channel state and the gain window
  localparam int CHANNELS    = 8;
  localparam int WINDOW      = 6;
  localparam int COUNT_LIMIT = 20;

  localparam int CH_AW   = $clog2(CHANNELS);
  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int DIFF_AW = $clog2(CHANNELS * WINDOW);
  localparam int CNT_W   = 5;
  localparam int SUM_W   = $clog2(WINDOW * 16) + 1;
  localparam int RUN_W   = 4;

  localparam logic signed [SUM_W-1:0] SETTLE_LIM = SUM_W'(WINDOW * 2 / 5);
  localparam logic [RUN_W-1:0]        RUN_MAX    = RUN_W'(8);

  // Decoder status bits
  localparam logic [7:0] STAT_LOSS = 8'h80;
  localparam logic [7:0] STAT_LOCK = 8'h68;
  localparam logic [7:0] LEVEL_TRIG = 8'h0A;

  // Decoder chip addresses
  localparam logic [7:0] DEV_LO = 8'h88;
  localparam logic [7:0] DEV_HI = 8'h8A;

  // Decoder registers
  localparam logic [7:0] REG_RESET = 8'h06;
  localparam logic [7:0] REG_MODE  = 8'h07;
  localparam logic [7:0] REG_AGC   = 8'h08;
  localparam logic [7:0] REG_PULSE = 8'h09;
  localparam logic [7:0] REG_SAT   = 8'h12;
  localparam logic [7:0] REG_HUE   = 8'h13;
  localparam logic [7:0] REG_SHARP = 8'h14;
  localparam logic [7:0] REG_CLAMP = 8'h3A;

  localparam logic [7:0] AGC_TAB [8] = '{8'hE0, 8'hE0, 8'hE0, 8'hE8, 8'hE8, 8'hE8, 8'hF8, 8'hF8};
  localparam logic [7:0] SAT_TAB [8] = '{8'h40, 8'h40, 8'h40, 8'h38, 8'h38, 8'h38, 8'h30, 8'h30};
  localparam logic [7:0] HUE_TAB [8] = '{8'h00, 8'h00, 8'h0C, 8'h0C, 8'h18, 8'h18, 8'h24, 8'h24};
  localparam logic [7:0] SHP_TAB [8] = '{8'h07, 8'h07, 8'h07, 8'h10, 8'h10, 8'h10, 8'h18, 8'h18};

  typedef enum logic [1:0] {
    KIND_LOSS,
    KIND_ACQ,
    KIND_SAMPLE
  } kind_e;

  // Per-channel tracking state, one word of the channel memory
  typedef struct packed {
    logic                     armed;
    logic                     tracking;
    logic                     pulse_done;
    logic [3:0]               prev_gain;
    logic [CNT_W-1:0]         count;
    logic [SLOT_W-1:0]        slot;
    logic signed [SUM_W-1:0]  sum;
  } chst_t;

  localparam chst_t CHST_RST = '{armed: 1'b1, default: '0};

  typedef struct packed {
    logic             rd_en;
    logic [CH_AW-1:0] rd_addr;
    logic             wr_en;
    logic [CH_AW-1:0] wr_addr;
  } chreq_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] value;
  } wr_t;

  // Register write number idx of a run of the given kind. A sample run holds
  // the two pulse writes first and the six final writes after them.
  function automatic wr_t egss_write(kind_e kind, logic [2:0] idx, logic [2:0] gain);
    wr_t w;
    logic low;
    w   = '0;
    low = (gain < 3'd3);
    unique case (kind)
      KIND_LOSS: begin
        w = idx[0] ? wr_t'{REG_MODE, 8'h0F} : wr_t'{REG_CLAMP, 8'h0A};
      end
      KIND_ACQ: begin
        case (idx[1:0])
          2'd0:    w = '{REG_RESET, 8'h80};
          2'd1:    w = '{REG_MODE, 8'h0F};
          default: w = '{REG_CLAMP, 8'h02};
        endcase
      end
      KIND_SAMPLE: begin
        case (idx)
          3'd0:    w = '{REG_PULSE, 8'h64};
          3'd1:    w = '{REG_PULSE, 8'h24};
          3'd2:    w = '{REG_MODE, low ? 8'h0B : {1'b0, gain, 4'hB}};
          3'd3:    w = '{REG_CLAMP, low ? 8'h0A : 8'h02};
          3'd4:    w = '{REG_AGC, AGC_TAB[gain]};
          3'd5:    w = '{REG_SAT, SAT_TAB[gain]};
          3'd6:    w = '{REG_HUE, HUE_TAB[gain]};
          default: w = '{REG_SHARP, SHP_TAB[gain]};
        endcase
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hdl/egss_chmem.sv
`default_nettype none

module egss_chmem (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire egss_pkg::chreq_t  req_i,
  input  wire egss_pkg::chst_t   wr_data_i,
  output egss_pkg::chst_t        rd_data_o
);
  import egss_pkg::*;

  chst_t                mem_q [CHANNELS];
  logic [CHANNELS-1:0]  valid_q;
  chst_t                rd_raw_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_raw_q <= mem_q[req_i.rd_addr];
    end
  end

  // Entries never written since reset read back as the reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_raw_q : CHST_RST;

endmodule

`default_nettype wire

// File: hdl/equalizer_gain_settle_sequencer.sv
`default_nettype none

// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tuser: action; tdata: channel, status_byte,
//                                            gain_nibble, level_byte, lost_at_wait
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: device_addr, sub_channel, reg_addr,
//                                            reg_value; tlast: last
//
// An item makes n = 0..8 register writes after a channel memory read, a window memory
// read, update and write-back, one write per cycle into the output register.
// The next item is accepted once the last write of the run sits in the output register.
// Reset marks all channel words invalid (they read as the reset state); no clearing pass.
// A low m_axis_tready holds the output register and the write sequencer.

module equalizer_gain_settle_sequencer (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // channel, status_byte, gain_nibble, level_byte,
                                      // lost_at_wait, zero fill
  input  wire         s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // device_addr, sub_channel, reg_addr, reg_value,
                                      // zero fill
  output logic        m_axis_tlast
);
  import egss_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RDST = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]  state_q, state_d;

  logic        act_q;
  logic [2:0]  ch_q;
  logic [7:0]  status_q;
  logic [3:0]  nib_q;
  logic [7:0]  level_q;
  logic [1:0]  lost_q;

  kind_e             kind_q, kind_d;
  logic [RUN_W-1:0]  idx_q, idx_d;
  logic [RUN_W-1:0]  end_q, end_d;
  logic [2:0]        gain_q, gain_d;

  logic [31:0] mdata_q;
  logic        mlast_q;
  logic        mvalid_q, mvalid_d;

  chreq_t      ch_req;
  chst_t       st, st_new;

  logic signed [4:0]  diff_mem [CHANNELS*WINDOW];
  logic signed [4:0]  diff_rd_q;
  logic [DIFF_AW-1:0] diff_addr_q, diff_addr_d;
  logic               diff_we;
  logic signed [4:0]  diff;

  logic               s_fire;
  logic               in_range;
  logic               locked;
  logic               pulse, fin;
  logic [2:0]         gain;
  logic [CNT_W:0]     cnt1;
  logic signed [SUM_W-1:0] sum_new;
  logic [SLOT_W-1:0]  slot_nxt;
  logic [RUN_W-1:0]   start_v, stop_v;
  kind_e              kind_v;
  logic               load;
  logic               is_last;
  wr_t                wr;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_range      = int'(s_axis_tdata[2:0]) < CHANNELS;

  egss_chmem u_chmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ch_req),
    .wr_data_i (st_new),
    .rd_data_o (st)
  );

  always_comb begin
    ch_req.rd_en   = s_fire && in_range;
    ch_req.rd_addr = s_axis_tdata[CH_AW-1:0];
    ch_req.wr_en   = (state_q == ST_CALC);
    ch_req.wr_addr = ch_q[CH_AW-1:0];
  end

  assign diff_addr_d = DIFF_AW'(int'(ch_q[CH_AW-1:0]) * WINDOW + int'(st.slot));

  // Write back the window entry only with the channel word
  always_ff @(posedge clk_i) begin
    if (diff_we && (state_q == ST_CALC)) begin
      diff_mem[diff_addr_q] <= diff;
    end
    if (state_q == ST_RDST) begin
      diff_rd_q   <= diff_mem[diff_addr_d];
      diff_addr_q <= diff_addr_d;
    end
  end

  // Update of the channel state and choice of the write run
  always_comb begin
    st_new   = st;
    start_v  = '0;
    stop_v   = '0;
    kind_v   = KIND_SAMPLE;
    diff_we  = 1'b0;
    locked   = (status_q & STAT_LOCK) == STAT_LOCK;
    pulse    = (level_q > LEVEL_TRIG) && !st.pulse_done;
    gain     = nib_q[3] ? 3'd7 : nib_q[2:0];
    diff     = {2'b00, gain} - {1'b0, st.prev_gain};
    cnt1     = {1'b0, st.count} + 1'b1;
    sum_new  = st.sum + SUM_W'(diff)
               - ((st.count >= CNT_W'(WINDOW)) ? SUM_W'(diff_rd_q) : '0);
    slot_nxt = (st.slot == SLOT_W'(WINDOW - 1)) ? '0 : st.slot + 1'b1;
    fin      = ((cnt1 >= (CNT_W+1)'(WINDOW)) && (sum_new < SETTLE_LIM))
               || (cnt1 >= (CNT_W+1)'(COUNT_LIMIT));
    if (!act_q) begin
      if ((status_q & STAT_LOSS) != '0) begin
        kind_v            = KIND_LOSS;
        stop_v            = RUN_W'(2);
        st_new.armed      = 1'b1;
        st_new.tracking   = 1'b0;
        st_new.pulse_done = 1'b0;
        st_new.prev_gain  = '0;
        st_new.count      = '0;
      end else if (locked && st.armed) begin
        kind_v       = KIND_ACQ;
        st_new.armed = 1'b0;
        if (lost_q == 2'd0) begin
          stop_v            = RUN_W'(3);
          st_new.tracking   = 1'b1;
          st_new.pulse_done = 1'b0;
          st_new.prev_gain  = nib_q;
          st_new.count      = '0;
          st_new.slot       = '0;
          st_new.sum        = '0;
        end else begin
          stop_v = {2'b00, lost_q};
        end
      end
    end else if (st.tracking) begin
      if (pulse) begin
        st_new.pulse_done = 1'b1;
      end
      if (pulse && (lost_q == 2'd1 || lost_q == 2'd2)) begin
        stop_v = {2'b00, lost_q};
      end else begin
        diff_we          = 1'b1;
        start_v          = pulse ? RUN_W'(0) : RUN_W'(2);
        st_new.prev_gain = {1'b0, gain};
        if (fin) begin
          stop_v          = RUN_MAX;
          st_new.tracking = 1'b0;
          st_new.count    = '0;
          st_new.slot     = '0;
          st_new.sum      = '0;
        end else begin
          stop_v       = RUN_W'(2);
          st_new.count = cnt1[CNT_W-1:0];
          st_new.slot  = slot_nxt;
          st_new.sum   = sum_new;
        end
      end
    end
  end

  assign wr      = egss_write(kind_q, idx_q[2:0], gain_q);
  assign is_last = (idx_q + 1'b1) == end_q;
  assign load    = (state_q == ST_EMIT) && (!mvalid_q || m_axis_tready);

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    idx_d    = idx_q;
    end_d    = end_q;
    gain_d   = gain_q;
    mvalid_d = mvalid_q;
    if (m_axis_tready) begin
      mvalid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && in_range) begin
          state_d = ST_RDST;
        end
      end
      ST_RDST: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        kind_d = kind_v;
        idx_d  = start_v;
        end_d  = stop_v;
        gain_d = gain;
        state_d = (start_v != stop_v) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (load) begin
          mvalid_d = 1'b1;
          idx_d    = idx_q + 1'b1;
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mvalid_q <= 1'b0;
      kind_q   <= KIND_LOSS;
      idx_q    <= '0;
      end_q    <= '0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
      kind_q   <= kind_d;
      idx_q    <= idx_d;
      end_q    <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gain_q <= gain_d;
    if (s_fire) begin
      act_q    <= s_axis_tuser;
      ch_q     <= s_axis_tdata[2:0];
      status_q <= s_axis_tdata[10:3];
      nib_q    <= s_axis_tdata[14:11];
      level_q  <= s_axis_tdata[22:15];
      lost_q   <= s_axis_tdata[24:23];
    end
    if (load) begin
      mdata_q <= {6'd0, wr.value, wr.addr, ~ch_q[1], ch_q[0], ch_q[2] ? DEV_HI : DEV_LO};
      mlast_q <= is_last;
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tlast  = mlast_q;

`ifndef SYNTH
  a_emit_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> (idx_q < end_q) && (end_q <= RUN_MAX))
    else $error("write index outside its run");

  a_no_rmw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ch_req.rd_en && ch_req.wr_en))
    else $error("channel memory read and write-back overlap");

  a_accept_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q == ST_RDST) || (state_q == ST_IDLE))
    else $error("accepted request did not start a memory read");

  a_last_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && is_last |=> state_q == ST_IDLE && mvalid_q && m_axis_tlast)
    else $error("final write did not close the run");
`endif

endmodule

`default_nettype wire
